// ===== src/edfs_pkg.sv =====
// ----------------------------------------------------------------------------
// EDF scheduler package
// Shared constants, codes and the flag bundle that moves along the cell chain.
// ----------------------------------------------------------------------------
package edfs_pkg;

	// Default sizes of the block.
	localparam int DEF_NUM_TASKS  = 8;
	localparam int DEF_TIME_WIDTH = 16;

	// Fixed field widths.
	localparam int SLOT_W  = 3;
	localparam int BURST_W = 16;
	localparam int EV_W    = 2;
	localparam int CNT_W   = 4;

	// Width used to compare slot numbers and counts against cell positions.
	localparam int IDX_CMP_W = 7;

	// Operation codes of an input word.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Event codes of a result word.
	localparam logic [EV_W-1:0] EV_IDLE = 2'd0;
	localparam logic [EV_W-1:0] EV_RUN  = 2'd1;
	localparam logic [EV_W-1:0] EV_MISS = 2'd2;
	localparam logic [EV_W-1:0] EV_DONE = 2'd3;

	// Flags handed from one cell to the next during a scan.
	typedef struct packed {
		logic tok;      // scan wave sits here
		logic found;    // a ready task has been seen
		logic pending;  // some used slot still has work
		logic one_left; // the best task has exactly one unit left
	} chain_flags_t;

endpackage

// ===== src/edfs_cell.sv =====
// ----------------------------------------------------------------------------
// EDF scheduler cell
// Holds one task slot and takes the scan wave one step further along the row.
// ----------------------------------------------------------------------------
module edfs_cell #(
	parameter int IDX        = 0,
	parameter int TIME_WIDTH = edfs_pkg::DEF_TIME_WIDTH,
	parameter int SW         = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [edfs_pkg::IDX_CMP_W-1:0]     used,
	input  logic [TIME_WIDTH-1:0]              cur_time,
	input  logic                               step,
	input  logic                               ld_en,
	input  logic [edfs_pkg::SLOT_W-1:0]        ld_slot,
	input  logic [TIME_WIDTH-1:0]              ld_arrival,
	input  logic [edfs_pkg::BURST_W-1:0]       ld_burst,
	input  logic [TIME_WIDTH-1:0]              ld_rel_dl,
	input  logic                               dec_en,
	input  logic [SW-1:0]                      dec_slot,
	input  edfs_pkg::chain_flags_t             flags_in,
	input  logic [TIME_WIDTH:0]                dl_in,
	input  logic [SW-1:0]                      slot_in,
	output edfs_pkg::chain_flags_t             flags_out,
	output logic [TIME_WIDTH:0]                dl_out,
	output logic [SW-1:0]                      slot_out,
	output logic                               miss_req
);
	import edfs_pkg::*;

	localparam logic [IDX_CMP_W-1:0] IDX_C = IDX_CMP_W'(IDX);
	localparam logic [SW-1:0]        IDX_S = SW'(IDX);

	logic [BURST_W-1:0]    rem_q;
	logic [TIME_WIDTH-1:0] arr_q;
	logic [TIME_WIDTH:0]   dl_q;
	chain_flags_t          flags_q;
	logic [TIME_WIDTH:0]   best_dl_q;
	logic [SW-1:0]         best_slot_q;

	logic         ld_hit;
	logic         dec_hit;
	logic         act;
	logic         rdy;
	logic         miss;
	logic         live;
	logic         cand;
	logic         take;
	chain_flags_t flags_nxt;

	assign ld_hit  = ld_en && (IDX_CMP_W'(ld_slot) == IDX_C);
	assign dec_hit = dec_en && (dec_slot == IDX_S);

	// Slot status against the current time.
	assign act  = (IDX_C < used) && (rem_q != '0);
	assign rdy  = arr_q <= cur_time;
	assign miss = act && rdy && ({1'b0, cur_time} > dl_q);
	assign live = act && !miss;
	assign cand = live && rdy;
	assign take = cand && (!flags_in.found || (dl_q < dl_in));

	assign miss_req = flags_in.tok && miss;

	// Running earliest-deadline choice handed to the next cell.
	always_comb begin
		flags_nxt.tok      = flags_in.tok;
		flags_nxt.found    = flags_in.found || cand;
		flags_nxt.pending  = flags_in.pending || live;
		flags_nxt.one_left = take ? (rem_q == BURST_W'(1)) : flags_in.one_left;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (step) begin
			flags_q <= flags_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			best_dl_q   <= take ? dl_q : dl_in;
			best_slot_q <= take ? IDX_S : slot_in;
		end
	end

	// Remaining work: written by a load, dropped on a miss, counted down on a run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ld_hit) begin
			rem_q <= ld_burst;
		end else if (step && miss_req) begin
			rem_q <= '0;
		end else if (dec_hit) begin
			rem_q <= rem_q - BURST_W'(1);
		end
	end

	// Arrival time and absolute deadline of the slot.
	always_ff @(posedge clk) begin
		if (ld_hit) begin
			arr_q <= ld_arrival;
			dl_q  <= {1'b0, ld_arrival} + {1'b0, ld_rel_dl};
		end
	end

	assign flags_out = flags_q;
	assign dl_out    = best_dl_q;
	assign slot_out  = best_slot_q;

endmodule

// ===== src/edf_task_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// EDF task scheduler, top level
// Earliest-deadline-first scheduler over a row of task slot cells.
//
//  Channel   Direction  Content
//  s_axis    in         tuser: operation; tdata: slot, arrival, burst, deadline
//  m_axis    out        tuser: event; tdata: slot, time stamp, finished; tlast
//  cfg       in         task count, written when cfg_we is high
//
// A load word is taken in the idle state. A tick word sends a scan wave
// through the NUM_TASKS cells, one cell per cycle unless a stalled miss word
// holds it; FIN then registers the run, idle or done word when the output is
// free and returns to idle for the next word. A miss word does not hold the
// wave while the output is free; a stalled output holds it at the cell with a
// miss to report. Reset clears all remaining work, the time and the task count.
// ----------------------------------------------------------------------------
module edf_task_scheduler_top #(
	parameter int NUM_TASKS  = edfs_pkg::DEF_NUM_TASKS,
	parameter int TIME_WIDTH = edfs_pkg::DEF_TIME_WIDTH,
	localparam int IN_DW  = edfs_pkg::SLOT_W + 2 * TIME_WIDTH + edfs_pkg::BURST_W,
	localparam int IN_TW  = ((IN_DW + 7) / 8) * 8,
	localparam int OUT_DW = edfs_pkg::SLOT_W + TIME_WIDTH + 1,
	localparam int OUT_TW = ((OUT_DW + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// slot, arrival, burst, relative_deadline (from bit 0 up)
	input  logic [IN_TW-1:0]              s_axis_tdata,
	// operation
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// task_slot, time_stamp, finished (from bit 0 up)
	output logic [OUT_TW-1:0]             m_axis_tdata,
	// event_res
	output logic [edfs_pkg::EV_W-1:0]     m_axis_tuser,
	output logic                          m_axis_tlast,
	input  logic                          cfg_we,
	input  logic [edfs_pkg::CNT_W-1:0]    cfg_wdata
);
	import edfs_pkg::*;

	localparam int SW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam logic [IDX_CMP_W-1:0] NT_C = IDX_CMP_W'(NUM_TASKS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [TIME_WIDTH-1:0]  time_q;
	logic                   st_q;
	logic                   fin_found_q;
	logic                   fin_pending_q;
	logic                   fin_one_q;
	logic [SW-1:0]          fin_slot_q;

	logic                   out_valid_q;
	logic [EV_W-1:0]        out_ev_q;
	logic [SLOT_W-1:0]      out_slot_q;
	logic [TIME_WIDTH-1:0]  out_ts_q;
	logic                   out_fin_q;
	logic                   out_last_q;

	// Input word fields.
	logic                   in_op;
	logic [SLOT_W-1:0]      in_slot;
	logic [TIME_WIDTH-1:0]  in_arrival;
	logic [BURST_W-1:0]     in_burst;
	logic [TIME_WIDTH-1:0]  in_rel_dl;

	logic                   in_acc;
	logic                   ld_en;
	logic                   out_free;
	logic                   step;
	logic                   miss_any;
	logic [SW-1:0]          miss_slot;
	logic [IDX_CMP_W-1:0]   used;
	logic [TIME_WIDTH-1:0]  time_inc;
	logic                   dec_en;
	logic                   fin_emit;

	chain_flags_t           fl_ch   [0:NUM_TASKS];
	logic [TIME_WIDTH:0]    dl_ch   [0:NUM_TASKS];
	logic [SW-1:0]          slot_ch [0:NUM_TASKS];
	logic [NUM_TASKS-1:0]   miss_vec;

	assign in_op      = s_axis_tuser;
	assign in_slot    = s_axis_tdata[SLOT_W-1:0];
	assign in_arrival = s_axis_tdata[SLOT_W +: TIME_WIDTH];
	assign in_burst   = s_axis_tdata[SLOT_W + TIME_WIDTH +: BURST_W];
	assign in_rel_dl  = s_axis_tdata[SLOT_W + TIME_WIDTH + BURST_W +: TIME_WIDTH];

	// Handshake and control strobes.
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign ld_en         = in_acc && (in_op == OP_LOAD);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign miss_any      = |miss_vec;
	assign step          = !(miss_any && !out_free);
	assign fin_emit      = (state_q == ST_FIN) && out_free;
	assign dec_en        = fin_emit && fin_found_q;
	assign time_inc      = (time_q == '1) ? time_q : time_q + TIME_WIDTH'(1);

	// Slots in use, limited to the number of cells.
	assign used = (IDX_CMP_W'(cnt_q) > NT_C) ? NT_C : IDX_CMP_W'(cnt_q);

	// Slot of the cell reporting a miss; at most one cell holds the wave.
	always_comb begin
		miss_slot = '0;
		for (int k = 0; k < NUM_TASKS; k++) begin
			if (miss_vec[k]) begin
				miss_slot = miss_slot | SW'(k);
			end
		end
	end

	// Head of the chain.
	always_comb begin
		fl_ch[0]     = '0;
		fl_ch[0].tok = st_q;
	end
	assign dl_ch[0]   = '0;
	assign slot_ch[0] = '0;

	// Row of task slot cells.
	for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
		edfs_cell #(
			.IDX        (g),
			.TIME_WIDTH (TIME_WIDTH),
			.SW         (SW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.used       (used),
			.cur_time   (time_q),
			.step       (step),
			.ld_en      (ld_en),
			.ld_slot    (in_slot),
			.ld_arrival (in_arrival),
			.ld_burst   (in_burst),
			.ld_rel_dl  (in_rel_dl),
			.dec_en     (dec_en),
			.dec_slot   (fin_slot_q),
			.flags_in   (fl_ch[g]),
			.dl_in      (dl_ch[g]),
			.slot_in    (slot_ch[g]),
			.flags_out  (fl_ch[g+1]),
			.dl_out     (dl_ch[g+1]),
			.slot_out   (slot_ch[g+1]),
			.miss_req   (miss_vec[g])
		);
	end

	// Task count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cfg_we) begin
			cnt_q <= cfg_wdata;
		end
	end

	// Sequencer for one tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			st_q    <= 1'b0;
			time_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ld_en) begin
						if (IDX_CMP_W'(in_slot) < NT_C) begin
							time_q <= '0;
						end
					end else if (in_acc) begin
						st_q    <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (step) begin
						st_q <= 1'b0;
					end
					if (fl_ch[NUM_TASKS].tok) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						if (fin_found_q || fin_pending_q) begin
							time_q <= time_inc;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Outcome of the scan, taken as the wave leaves the last cell.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && fl_ch[NUM_TASKS].tok) begin
			fin_found_q   <= fl_ch[NUM_TASKS].found;
			fin_pending_q <= fl_ch[NUM_TASKS].pending;
			fin_one_q     <= fl_ch[NUM_TASKS].one_left;
			fin_slot_q    <= slot_ch[NUM_TASKS];
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((miss_any && out_free) || fin_emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (miss_any && out_free) begin
			out_ev_q   <= EV_MISS;
			out_slot_q <= SLOT_W'(miss_slot);
			out_ts_q   <= time_q;
			out_fin_q  <= 1'b0;
			out_last_q <= 1'b0;
		end else if (fin_emit) begin
			out_last_q <= 1'b1;
			if (fin_found_q) begin
				out_ev_q   <= EV_RUN;
				out_slot_q <= SLOT_W'(fin_slot_q);
				out_ts_q   <= time_inc;
				out_fin_q  <= fin_one_q;
			end else if (fin_pending_q) begin
				out_ev_q   <= EV_IDLE;
				out_slot_q <= '0;
				out_ts_q   <= time_inc;
				out_fin_q  <= 1'b0;
			end else begin
				out_ev_q   <= EV_DONE;
				out_slot_q <= '0;
				out_ts_q   <= time_q;
				out_fin_q  <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_ev_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = OUT_TW'({out_fin_q, out_ts_q, out_slot_q});

endmodule

// ===== sim/edf_event_board_pkg.sv =====
// ----------------------------------------------------------------------------
// EDF scheduler event board
// Keeps a shadow copy of the scheduler's task table. It works out the words
// that each accepted tick must produce and checks the result words against
// them in order.
// ----------------------------------------------------------------------------
package edf_event_board_pkg;

	import edfs_pkg::*;

	localparam int SLOTS = DEF_NUM_TASKS;
	localparam int TW    = DEF_TIME_WIDTH;

	// One result word, split into its fields.
	typedef struct packed {
		logic [EV_W-1:0]   ev;
		logic [SLOT_W-1:0] slot;
		logic [TW-1:0]     stamp;
		logic              fin;
		logic              lst;
	} sched_event_t;

	class edf_event_board;

		sched_event_t       due_events[$];
		logic [BURST_W-1:0] work_left[SLOTS];
		logic [TW-1:0]      ready_at[SLOTS];
		logic [TW:0]        due_at[SLOTS];
		logic [TW-1:0]      now;
		logic [CNT_W-1:0]   slots_used;
		int                 errors;

		function new();
			foreach (work_left[i]) begin
				work_left[i] = '0;
				ready_at[i]  = '0;
				due_at[i]    = '0;
			end
			now        = '0;
			slots_used = '0;
			errors     = 0;
		endfunction

		function void set_count(logic [CNT_W-1:0] n);
			slots_used = n;
		endfunction

		function int outstanding();
			return due_events.size();
		endfunction

		// Apply one accepted input word and queue the result words it causes.
		function void note_word(logic op, logic [SLOT_W-1:0] slot, logic [TW-1:0] arr,
				logic [BURST_W-1:0] burst, logic [TW-1:0] dl);
			int   used;
			int   sel;
			logic found;
			logic busy;
			if (op == OP_LOAD) begin
				ready_at[slot]  = arr;
				work_left[slot] = burst;
				due_at[slot]    = {1'b0, arr} + {1'b0, dl};
				now             = '0;
				return;
			end
			used  = (slots_used > SLOTS) ? SLOTS : int'(slots_used);
			sel   = 0;
			found = 1'b0;
			busy  = 1'b0;

			// Tasks that are ready, unfinished and past their deadline are dropped.
			for (int i = 0; i < used; i++) begin
				if (work_left[i] != 0 && ready_at[i] <= now && {1'b0, now} > due_at[i]) begin
					work_left[i] = '0;
					due_events.push_back('{EV_MISS, SLOT_W'(i), now, 1'b0, 1'b0});
				end
			end

			// Earliest absolute deadline among ready tasks; the lowest slot wins a tie.
			for (int i = 0; i < used; i++) begin
				if (work_left[i] != 0) begin
					busy = 1'b1;
					if (ready_at[i] <= now && (!found || due_at[i] < due_at[sel])) begin
						found = 1'b1;
						sel   = i;
					end
				end
			end

			if (found) begin
				work_left[sel] = work_left[sel] - 1'b1;
				if (now != '1)
					now = now + 1'b1;
				due_events.push_back('{EV_RUN, SLOT_W'(sel), now, work_left[sel] == 0, 1'b1});
			end else if (busy) begin
				if (now != '1)
					now = now + 1'b1;
				due_events.push_back('{EV_IDLE, '0, now, 1'b0, 1'b1});
			end else begin
				due_events.push_back('{EV_DONE, '0, now, 1'b0, 1'b1});
			end
		endfunction

		// Compare one result word with the oldest expected word.
		function void check_word(sched_event_t got);
			sched_event_t want;
			if (due_events.size() == 0) begin
				errors++;
				$error("unexpected result word: event_res %0d task_slot %0d time_stamp %0d",
					got.ev, got.slot, got.stamp);
				return;
			end
			want = due_events.pop_front();
			if (got.ev !== want.ev) begin
				errors++;
				$error("event_res: expected %0d, got %0d", want.ev, got.ev);
			end
			if (got.slot !== want.slot) begin
				errors++;
				$error("task_slot: expected %0d, got %0d", want.slot, got.slot);
			end
			if (got.stamp !== want.stamp) begin
				errors++;
				$error("time_stamp: expected %0d, got %0d", want.stamp, got.stamp);
			end
			if (got.fin !== want.fin) begin
				errors++;
				$error("finished: expected %0d, got %0d", want.fin, got.fin);
			end
			if (got.lst !== want.lst) begin
				errors++;
				$error("last: expected %0d, got %0d", want.lst, got.lst);
			end
		endfunction

	endclass

endpackage

// ===== sim/edf_task_scheduler_top_tb.sv =====
// ----------------------------------------------------------------------------
// EDF task scheduler testbench
// Loads task tables, sweeps the task count and ticks the scheduler while
// both stream sides idle and stall at random. Every result word is checked
// against a shadow model of the slot table.
// ----------------------------------------------------------------------------
module edf_task_scheduler_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import edfs_pkg::*;
	import edf_event_board_pkg::*;

	localparam int RAND_ITEMS = 130;
	localparam int SETTLE     = DEF_NUM_TASKS + 12;
	localparam int IDLE_LIMIT = 2000;

	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [55:0]           s_axis_tdata  = '0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [23:0]           m_axis_tdata;
	logic [EV_W-1:0]       m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_we        = 1'b0;
	logic [CNT_W-1:0]      cfg_wdata     = '0;

	edf_event_board board;
	rx_mode_t       rx_mode   = RX_FREE;
	int             gap_max   = 0;
	int             burst_left = 0;
	int             cur_count = 0;
	int             cyc       = 0;
	int             quiet     = 0;
	int             rand_items;
	int             n_load;
	int             n_tick;

	edf_task_scheduler_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver stall pattern, chosen per phase by the stimulus.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		case (rx_mode)
			RX_FREE: begin
				m_axis_tready <= 1'b1;
			end
			RX_COIN: begin
				m_axis_tready <= 1'($urandom_range(0, 1));
			end
			RX_SLOW: begin
				m_axis_tready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				m_axis_tready <= ((cyc % 23) < 9);
			end
		endcase
	end

	// Result checking and the no-progress watchdog.
	always @(posedge clk) begin
		sched_event_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.ev    = m_axis_tuser;
				got.slot  = m_axis_tdata[2:0];
				got.stamp = m_axis_tdata[18:3];
				got.fin   = m_axis_tdata[19];
				got.lst   = m_axis_tlast;
				board.check_word(got);
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
				quiet <= 0;
			end else if (quiet == IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// Present one word and hold it until the block takes it. The sender
	// works in bursts with random gaps whenever gap_max is nonzero.
	task automatic send_word(input logic op, input logic [2:0] slot, input logic [15:0] arr,
			input logic [15:0] burst, input logic [15:0] dl);
		int gap;
		if (gap_max > 0 && burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, gap_max);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 6);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {5'b0, dl, burst, arr, slot};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_word(op, slot, arr, burst, dl);
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic send_load(input logic [2:0] slot, input logic [15:0] arr,
			input logic [15:0] burst, input logic [15:0] dl);
		send_word(OP_LOAD, slot, arr, burst, dl);
	endtask

	// The payload of a tick is don't-care, so it carries random bits.
	task automatic send_tick();
		send_word(OP_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// Let every expected word come out, then give a load time to settle.
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] n);
		wait_drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		board.set_count(n);
		cur_count = n;
		cfg_we    <= 1'b0;
	endtask

	// Mostly small times so that tasks interact, sometimes the maximum or any value.
	function automatic logic [15:0] pick_time(input int lim);
		case ($urandom_range(0, 9))
			0:       return 16'hFFFF;
			1:       return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, lim));
		endcase
	endfunction

	// Mostly slots in use, sometimes any slot.
	function automatic logic [2:0] pick_slot();
		if ($urandom_range(0, 4) == 0 || cur_count == 0)
			return 3'($urandom_range(0, 7));
		return 3'($urandom_range(0, (cur_count > 8 ? 8 : cur_count) - 1));
	endfunction

	initial begin
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No slots in use: every tick reports all done.
		rx_mode = RX_COIN;
		gap_max = 4;
		send_tick();
		send_load(3'd0, 16'd0, 16'd3, 16'd2);
		send_tick();

		// A count above the slot total uses all eight slots. Equal deadlines go
		// to the lower slot, a zero burst is finished from the start, and a task
		// with the latest arrival and deadline overflows into the wide deadline.
		write_count(4'd15);
		send_load(3'd0, 16'd0, 16'd2, 16'd3);
		send_load(3'd1, 16'd0, 16'd0, 16'd0);
		send_load(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_load(3'd2, 16'd1, 16'd3, 16'd1);
		send_load(3'd3, 16'd0, 16'd1, 16'd3);
		repeat (6) send_tick();

		// Every slot misses on the same tick, which then reports all done.
		write_count(4'd8);
		for (int i = 0; i < 8; i++)
			send_load(3'(i), 16'd0, 16'd5, 16'd0);
		repeat (2) send_tick();

		// One task that arrives at the latest time keeps the clock idling.
		write_count(4'd1);
		rx_mode = RX_FREE;
		gap_max = 0;
		send_load(3'd0, 16'hFFFF, 16'd2, 16'd0);
		repeat (4) send_tick();

		// Random task tables with noise loads mixed into the ticks.
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			if ($urandom_range(0, 2) != 0)
				write_count(($urandom_range(0, 7) == 0) ? CNT_W'($urandom_range(9, 15))
					: CNT_W'($urandom_range(0, 8)));
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			n_load  = $urandom_range(1, 8);
			n_tick  = $urandom_range(2, 24);
			repeat (n_load) begin
				send_load(pick_slot(), pick_time(5), pick_time(4), pick_time(7));
				rand_items++;
			end
			repeat (n_tick) begin
				if ($urandom_range(0, 15) == 0)
					send_load(pick_slot(), pick_time(5), pick_time(4), pick_time(7));
				else
					send_tick();
				rand_items++;
			end
		end

		wait_drain();
		if (board.errors == 0 && board.outstanding() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
